// File: rtl/lrap_pkg.sv
// Shared constants and types for the line rasterizer with additive plotting.
// No dependencies; every module of the block imports this package.
package lrap_pkg;

	localparam int SCREEN_WIDTH  = 640;
	localparam int SCREEN_HEIGHT = 480;
	localparam int COORD_BITS    = 13;
	localparam int STORE_SIZE    = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int IDX_BITS      = $clog2(STORE_SIZE);
	localparam int CHAN_BITS     = 8;
	localparam int CNT_BITS      = COORD_BITS + 1;

	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

	localparam logic [CHAN_BITS-1:0] CHAN_MAX = CHAN_BITS'(255);

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
	} color_t;

	// One pixel of a line; color is the plot color on the way in and the
	// blended result on the way out.
	typedef struct packed {
		coord_t              x;
		coord_t              y;
		logic                on;
		logic [IDX_BITS-1:0] idx;
		logic                last;
		color_t              color;
	} pix_t;

endpackage

// File: rtl/lrap_front.sv
// Line walker: takes start and step items, keeps the Bresenham state and
// emits one pixel descriptor per step of an active line. Uses lrap_pkg.
module lrap_front import lrap_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic                 mode,
	input  coord_t               start_x,
	input  coord_t               start_y,
	input  coord_t               end_x,
	input  coord_t               end_y,
	input  logic [CHAN_BITS-1:0] line_red,
	input  logic [CHAN_BITS-1:0] line_green,
	input  logic [CHAN_BITS-1:0] line_blue,
	output logic                 pix_valid,
	output pix_t                 pix
);

	logic                  active_q;
	coord_t                cur_x_q, cur_y_q;
	logic [CNT_BITS-1:0]   err_q;
	logic [COORD_BITS-1:0] major_q, minor_q;
	logic [CNT_BITS-1:0]   left_q;
	logic                  xneg_q, yneg_q, xmaj_q;
	color_t                color_q;

	logic signed [COORD_BITS:0] dx_s, dy_s, dx_m, dy_m;
	logic [COORD_BITS-1:0]      dx_abs, dy_abs, major_d, minor_d;
	logic                       xmaj_d;
	logic [CNT_BITS-1:0]        err_sum, err_next;
	logic                       bump, x_adv, y_adv, last;
	coord_t                     x_inc, y_inc;
	logic                       start_fire, step_fire;

	assign start_fire = fire && (mode == MODE_START);
	assign step_fire  = fire && (mode == MODE_STEP) && active_q;

	// Setup for a new line
	always_comb begin
		dx_s    = (COORD_BITS+1)'(end_x) - (COORD_BITS+1)'(start_x);
		dy_s    = (COORD_BITS+1)'(end_y) - (COORD_BITS+1)'(start_y);
		dx_m    = -dx_s;
		dy_m    = -dy_s;
		dx_abs  = dx_s[COORD_BITS] ? dx_m[COORD_BITS-1:0] : dx_s[COORD_BITS-1:0];
		dy_abs  = dy_s[COORD_BITS] ? dy_m[COORD_BITS-1:0] : dy_s[COORD_BITS-1:0];
		xmaj_d  = dx_abs >= dy_abs;
		major_d = xmaj_d ? dx_abs : dy_abs;
		minor_d = xmaj_d ? dy_abs : dx_abs;
	end

	// One step of the walk
	always_comb begin
		err_sum  = err_q + {1'b0, minor_q};
		bump     = err_sum >= {1'b0, major_q};
		err_next = bump ? err_sum - {1'b0, major_q} : err_sum;
		x_adv    = xmaj_q || bump;
		y_adv    = !xmaj_q || bump;
		x_inc    = xneg_q ? coord_t'(-1) : coord_t'(1);
		y_inc    = yneg_q ? coord_t'(-1) : coord_t'(1);
		last     = left_q <= CNT_BITS'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (start_fire) begin
			active_q <= 1'b1;
		end else if (step_fire) begin
			active_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (start_fire) begin
			cur_x_q <= start_x;
			cur_y_q <= start_y;
			major_q <= major_d;
			minor_q <= minor_d;
			err_q   <= {1'b0, major_d >> 1};
			left_q  <= {1'b0, major_d} + CNT_BITS'(1);
			xneg_q  <= dx_s[COORD_BITS];
			yneg_q  <= dy_s[COORD_BITS];
			xmaj_q  <= xmaj_d;
			color_q <= '{red: line_red, green: line_green, blue: line_blue};
		end else if (step_fire) begin
			err_q   <= err_next;
			left_q  <= left_q - CNT_BITS'(1);
			if (x_adv) begin
				cur_x_q <= cur_x_q + x_inc;
			end
			if (y_adv) begin
				cur_y_q <= cur_y_q + y_inc;
			end
		end
	end

	// Classify the current pixel and form its store address
	always_comb begin
		pix.x     = cur_x_q;
		pix.y     = cur_y_q;
		pix.on    = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1]
		         && ({1'b0, cur_x_q} < (COORD_BITS+1)'(SCREEN_WIDTH))
		         && ({1'b0, cur_y_q} < (COORD_BITS+1)'(SCREEN_HEIGHT));
		pix.idx   = pix.on ? IDX_BITS'($unsigned(cur_x_q))
		          + IDX_BITS'($unsigned(cur_y_q)) * IDX_BITS'(SCREEN_WIDTH)
		          : '0;
		pix.last  = last;
		pix.color = color_q;
	end

	assign pix_valid = step_fire;

endmodule

// File: rtl/lrap_queue.sv
// Short pixel queue between the walker and the blend stage.
// Uses pix_t and the queue depth from lrap_pkg.
module lrap_queue import lrap_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  pix_t din,
	input  logic pop,
	output pix_t dout,
	output logic valid,
	output logic full
);

	pix_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QPTR_BITS:0]   count_q;

	assign valid = count_q != '0;
	assign full  = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_q <= rd_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_BITS+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_BITS+1)'(1);
			end
		end
	end

endmodule

// File: rtl/lrap_back.sv
// Blend stage: frame store, read-modify-write with saturating add, clear
// pass after reset and a two-entry result buffer. Uses lrap_pkg.
module lrap_back import lrap_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  pix_t q_head,
	input  logic q_valid,
	output logic q_pop,
	output logic clearing,
	output pix_t res,
	output logic res_empty,
	input  logic res_pop
);

	color_t              store [STORE_SIZE];
	color_t              rd_q;
	logic                clear_q;
	logic [IDX_BITS-1:0] clr_addr_q;

	logic   s1_valid_q;
	pix_t   s1_q;
	logic   fwd_q;
	color_t fwd_data_q;

	pix_t   obuf_q [2];
	logic   owr_q, ord_q;
	logic [1:0] ocount_q;

	color_t old_color, new_color;
	pix_t   out_pix;
	logic   out_room, s1_adv, s1_load, bypass, res_fire;
	logic [CHAN_BITS:0] sum_r, sum_g, sum_b;

	assign clearing = clear_q;
	assign res_fire = res_pop && !res_empty;
	assign out_room = (ocount_q != 2'd2) || res_fire;
	assign s1_adv   = s1_valid_q && out_room;
	assign s1_load  = q_valid && !clear_q && (!s1_valid_q || s1_adv);
	assign q_pop    = s1_load;
	// A pixel written this cycle at the address being read: take it directly
	assign bypass   = s1_adv && s1_q.on && q_head.on && (s1_q.idx == q_head.idx);

	always_comb begin
		old_color = fwd_q ? fwd_data_q : rd_q;
		sum_r = {1'b0, old_color.red}   + {1'b0, s1_q.color.red};
		sum_g = {1'b0, old_color.green} + {1'b0, s1_q.color.green};
		sum_b = {1'b0, old_color.blue}  + {1'b0, s1_q.color.blue};
		new_color.red   = sum_r[CHAN_BITS] ? CHAN_MAX : sum_r[CHAN_BITS-1:0];
		new_color.green = sum_g[CHAN_BITS] ? CHAN_MAX : sum_g[CHAN_BITS-1:0];
		new_color.blue  = sum_b[CHAN_BITS] ? CHAN_MAX : sum_b[CHAN_BITS-1:0];
		// Drop the color of an off-screen pixel
		out_pix       = s1_q;
		out_pix.color = s1_q.on ? new_color : '0;
	end

	// Frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (clear_q) begin
			store[clr_addr_q] <= '0;
		end else if (s1_adv && s1_q.on) begin
			store[s1_q.idx] <= new_color;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			rd_q <= store[q_head.idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
		end else if (clear_q) begin
			clr_addr_q <= clr_addr_q + IDX_BITS'(1);
			if (clr_addr_q == IDX_BITS'(STORE_SIZE - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_load) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			s1_q       <= q_head;
			fwd_q      <= bypass;
			fwd_data_q <= new_color;
		end
	end

	// Result buffer
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			obuf_q[owr_q] <= out_pix;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q    <= 1'b0;
			ord_q    <= 1'b0;
			ocount_q <= '0;
		end else begin
			if (s1_adv) begin
				owr_q <= !owr_q;
			end
			if (res_fire) begin
				ord_q <= !ord_q;
			end
			if (s1_adv && !res_fire) begin
				ocount_q <= ocount_q + 2'd1;
			end else if (res_fire && !s1_adv) begin
				ocount_q <= ocount_q - 2'd1;
			end
		end
	end

	assign res       = obuf_q[ord_q];
	assign res_empty = ocount_q == '0;

endmodule

// File: rtl/line_rasterizer_additive_plot.sv
// Top level of the line rasterizer with additive plotting.
// Instantiates lrap_front, lrap_queue and lrap_back; uses lrap_pkg.
//
// Usage:
//   Input channel: an item transfers on a rising edge with push high and
//   full low. mode 0 starts a line (endpoints and color), mode 1 advances
//   one pixel. A start gives no result; a step with no active line gives
//   none either. A start during an active line replaces it.
//   Result channel: while empty is low the oldest pixel is on the result
//   ports; it transfers on a rising edge with pop high.
//   A step's pixel reaches the result ports via queue, s1 and result
//   buffer. Throughput: one item per cycle while full is low, set by the
//   walker's combinational error update and the frame store's one-port
//   read-modify-write (back-to-back hits on one address are forwarded).
//   Reset: the frame store is swept to zero, one entry a cycle, over all
//   SCREEN_WIDTH * SCREEN_HEIGHT entries (307200); full stays high meanwhile.
//   Stall: when pop stays low the two-entry result buffer and the
//   four-entry pixel queue fill, then full rises; nothing is dropped.
module line_rasterizer_additive_plot import lrap_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 mode,
	input  coord_t               start_x,
	input  coord_t               start_y,
	input  coord_t               end_x,
	input  coord_t               end_y,
	input  logic [CHAN_BITS-1:0] line_red,
	input  logic [CHAN_BITS-1:0] line_green,
	input  logic [CHAN_BITS-1:0] line_blue,
	output logic                 empty,
	input  logic                 pop,
	output coord_t               pixel_x,
	output coord_t               pixel_y,
	output logic                 on_screen,
	output logic [IDX_BITS-1:0]  pixel_index,
	output logic [CHAN_BITS-1:0] new_red,
	output logic [CHAN_BITS-1:0] new_green,
	output logic [CHAN_BITS-1:0] new_blue,
	output logic                 last_pixel
);

	logic in_fire, pix_valid, q_valid, q_full, q_pop, clearing;
	pix_t pix, q_head, res;

	assign full    = q_full || clearing;
	assign in_fire = push && !full;

	lrap_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (in_fire),
		.mode       (mode),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.line_red   (line_red),
		.line_green (line_green),
		.line_blue  (line_blue),
		.pix_valid  (pix_valid),
		.pix        (pix)
	);

	lrap_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (pix_valid),
		.din    (pix),
		.pop    (q_pop),
		.dout   (q_head),
		.valid  (q_valid),
		.full   (q_full)
	);

	lrap_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_head    (q_head),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.clearing  (clearing),
		.res       (res),
		.res_empty (empty),
		.res_pop   (pop)
	);

	assign pixel_x     = res.x;
	assign pixel_y     = res.y;
	assign on_screen   = res.on;
	assign pixel_index = res.idx;
	assign new_red     = res.color.red;
	assign new_green   = res.color.green;
	assign new_blue    = res.color.blue;
	assign last_pixel  = res.last;

endmodule

// File: verif/line_rasterizer_additive_plot_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for line_rasterizer_additive_plot: line starts and pixel steps
// go in through the push/full queue, and a pixel walker with its own frame store copy
// predicts every pop. Depends on lrap_pkg and the RTL of the block.
module line_rasterizer_additive_plot_tb;
	import lrap_pkg::*;

	typedef struct {
		logic   mode;
		coord_t sx;
		coord_t sy;
		coord_t ex;
		coord_t ey;
		color_t color;
	} line_cmd_t;

	logic                 clk;
	logic                 arst_n;
	logic                 push;
	logic                 full;
	logic                 mode;
	coord_t               start_x;
	coord_t               start_y;
	coord_t               end_x;
	coord_t               end_y;
	logic [CHAN_BITS-1:0] line_red;
	logic [CHAN_BITS-1:0] line_green;
	logic [CHAN_BITS-1:0] line_blue;
	logic                 empty;
	logic                 pop = 1'b0;
	coord_t               pixel_x;
	coord_t               pixel_y;
	logic                 on_screen;
	logic [IDX_BITS-1:0]  pixel_index;
	logic [CHAN_BITS-1:0] new_red;
	logic [CHAN_BITS-1:0] new_green;
	logic [CHAN_BITS-1:0] new_blue;
	logic                 last_pixel;

	line_rasterizer_additive_plot u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.start_x     (start_x),
		.start_y     (start_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.line_red    (line_red),
		.line_green  (line_green),
		.line_blue   (line_blue),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.on_screen   (on_screen),
		.pixel_index (pixel_index),
		.new_red     (new_red),
		.new_green   (new_green),
		.new_blue    (new_blue),
		.last_pixel  (last_pixel)
	);

	// walker state of the predictor
	bit     walk_active;
	coord_t walk_x;
	coord_t walk_y;
	int     walk_err;
	int     walk_major;
	int     walk_minor;
	int     walk_left;
	bit     walk_x_down;
	bit     walk_y_down;
	bit     walk_x_major;
	color_t walk_color;
	color_t shadow_fb [STORE_SIZE];
	pix_t   pixel_queue [$];

	int mismatch_count;
	int items_sent;
	int burst_left;
	int pop_run;
	int pop_kind;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(12_000_000);
		$display("line_rasterizer_additive_plot verification failed");
		$finish;
	end

	function automatic logic [CHAN_BITS-1:0] sat_channel(input int a, input int b);
		int s;
		s = a + b;
		return (s > int'(CHAN_MAX)) ? CHAN_MAX : CHAN_BITS'(s);
	endfunction

	function automatic int line_pixels(input int sx, input int sy, input int ex, input int ey);
		int dx;
		int dy;
		dx = (ex >= sx) ? ex - sx : sx - ex;
		dy = (ey >= sy) ? ey - sy : sy - ey;
		return ((dx >= dy) ? dx : dy) + 1;
	endfunction

	function automatic line_cmd_t make_start(input int sx, input int sy, input int ex,
			input int ey, input color_t color);
		line_cmd_t cmd;
		cmd.mode  = MODE_START;
		cmd.sx    = coord_t'(sx);
		cmd.sy    = coord_t'(sy);
		cmd.ex    = coord_t'(ex);
		cmd.ey    = coord_t'(ey);
		cmd.color = color;
		return cmd;
	endfunction

	// endpoint and color fields are don't-care on a step: fill them with junk
	function automatic line_cmd_t make_step();
		line_cmd_t cmd;
		cmd.mode  = MODE_STEP;
		cmd.sx    = coord_t'($urandom);
		cmd.sy    = coord_t'($urandom);
		cmd.ex    = coord_t'($urandom);
		cmd.ey    = coord_t'($urandom);
		cmd.color = color_t'($urandom);
		return cmd;
	endfunction

	task automatic predict_item(input line_cmd_t cmd);
		int     x1;
		int     y1;
		int     x2;
		int     y2;
		int     dx;
		int     dy;
		int     nx;
		int     ny;
		int     idx;
		pix_t   p;
		color_t old;
		if (cmd.mode == MODE_START) begin
			x1 = cmd.sx;
			y1 = cmd.sy;
			x2 = cmd.ex;
			y2 = cmd.ey;
			dx = (x2 >= x1) ? x2 - x1 : x1 - x2;
			dy = (y2 >= y1) ? y2 - y1 : y1 - y2;
			walk_x_down  = x2 < x1;
			walk_y_down  = y2 < y1;
			walk_x_major = dx >= dy;
			walk_major   = walk_x_major ? dx : dy;
			walk_minor   = walk_x_major ? dy : dx;
			walk_err     = walk_major / 2;
			walk_left    = walk_major + 1;
			walk_x       = cmd.sx;
			walk_y       = cmd.sy;
			walk_color   = cmd.color;
			walk_active  = 1'b1;
		end else if (walk_active) begin
			nx = walk_x;
			ny = walk_y;
			p = '0;
			p.x = walk_x;
			p.y = walk_y;
			p.on = nx >= 0 && nx < SCREEN_WIDTH && ny >= 0 && ny < SCREEN_HEIGHT;
			if (p.on) begin
				idx = nx + ny * SCREEN_WIDTH;
				old = shadow_fb[idx];
				p.idx = IDX_BITS'(idx);
				p.color.red   = sat_channel(old.red, walk_color.red);
				p.color.green = sat_channel(old.green, walk_color.green);
				p.color.blue  = sat_channel(old.blue, walk_color.blue);
				shadow_fb[idx] = p.color;
			end
			p.last = walk_left <= 1;
			walk_err += walk_minor;
			if (walk_err >= walk_major) begin
				walk_err -= walk_major;
				if (walk_x_major)
					ny += walk_y_down ? -1 : 1;
				else
					nx += walk_x_down ? -1 : 1;
			end
			if (walk_x_major)
				nx += walk_x_down ? -1 : 1;
			else
				ny += walk_y_down ? -1 : 1;
			walk_x = coord_t'(nx);
			walk_y = coord_t'(ny);
			if (walk_left > 0)
				walk_left--;
			if (walk_left == 0)
				walk_active = 1'b0;
			pixel_queue.push_back(p);
		end
	endtask

	task automatic check_pixel();
		pix_t got;
		pix_t want;
		got.x     = pixel_x;
		got.y     = pixel_y;
		got.on    = on_screen;
		got.idx   = pixel_index;
		got.last  = last_pixel;
		got.color = {new_red, new_green, new_blue};
		if (pixel_queue.size() == 0) begin
			if (mismatch_count < 10)
				$display("%0t: unexpected pixel x=%0d y=%0d on=%0b idx=%0d", $realtime,
					got.x, got.y, got.on, got.idx);
			mismatch_count++;
		end else begin
			want = pixel_queue.pop_front();
			if (got.x !== want.x || got.y !== want.y || got.on !== want.on ||
					got.idx !== want.idx || got.last !== want.last ||
					got.color.red !== want.color.red ||
					got.color.green !== want.color.green ||
					got.color.blue !== want.color.blue) begin
				if (mismatch_count < 10)
					$display({"%0t: pixel mismatch: expected x=%0d y=%0d on=%0b idx=%0d ",
						"rgb=%h last=%0b, got x=%0d y=%0d on=%0b idx=%0d rgb=%h last=%0b"},
						$realtime, want.x, want.y, want.on, want.idx, want.color,
						want.last, got.x, got.y, got.on, got.idx, got.color, got.last);
				mismatch_count++;
			end
		end
	endtask

	// check the older pixel before modeling the item taken at the same edge
	always @(posedge clk) begin : watch_ports
		line_cmd_t seen;
		if (arst_n) begin
			if (pop && !empty)
				check_pixel();
			if (push && !full) begin
				seen.mode  = mode;
				seen.sx    = start_x;
				seen.sy    = start_y;
				seen.ex    = end_x;
				seen.ey    = end_y;
				seen.color = {line_red, line_green, line_blue};
				predict_item(seen);
			end
		end
	end

	// receiver: runs of steady pops, coin-flip pops and hard stalls
	always @(posedge clk) begin
		if (pop_run == 0) begin
			pop_kind = $urandom_range(0, 2);
			pop_run = (pop_kind == 2) ? $urandom_range(1, 8) : $urandom_range(10, 60);
		end
		pop_run--;
		case (pop_kind)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			default: pop <= 1'b0;
		endcase
	end

	// call at a rising edge; returns at the edge of the transfer or after a gap
	task automatic send_item(input line_cmd_t cmd);
		int gap;
		mode       <= cmd.mode;
		start_x    <= cmd.sx;
		start_y    <= cmd.sy;
		end_x      <= cmd.ex;
		end_y      <= cmd.ey;
		line_red   <= cmd.color.red;
		line_green <= cmd.color.green;
		line_blue  <= cmd.color.blue;
		push       <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
	endtask

	task automatic run_line(input int sx, input int sy, input int ex, input int ey,
			input color_t color, input int steps);
		send_item(make_start(sx, sy, ex, ey, color));
		repeat (steps) send_item(make_step());
	endtask

	task automatic test_directed();
		send_item(make_step());
		run_line(639, 479, 639, 479, 24'hFFFFFF, 1);
		send_item(make_step());
		run_line(-4096, 4095, 4095, -4096, 24'h000000, 2);
		run_line(0, 0, 0, 0, {8'd200, 8'd1, 8'd128}, 1);
		// second hit on the same pixel saturates red and blue
		run_line(0, 0, 0, 0, {8'd100, 8'd0, 8'd255}, 1);
		// equal deltas, walks in from off the right edge
		run_line(641, -1, 638, 2, color_t'($urandom), 4);
		// cut short below the screen, then restart
		run_line(5, 479, 7, 483, color_t'($urandom), 2);
		run_line(4095, -4096, -4096, 4095, 24'hFFFFFF, 1);
		run_line(10, 20, 9, 23, color_t'($urandom), 4);
	endtask

	task automatic test_long_lines();
		int y0;
		int x0;
		y0 = $urandom_range(0, 479);
		run_line(-60, y0, 120, y0 + int'($urandom_range(0, 60)) - 30, color_t'($urandom),
			181);
		x0 = $urandom_range(0, 600);
		run_line(x0, 400, x0 + 30, 560, color_t'($urandom), 161);
		run_line(560, 380, 700, 520, color_t'($urandom), 141);
	endtask

	task automatic test_full_range_restart(input int n_lines);
		repeat (n_lines)
			run_line(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), color_t'($urandom), $urandom_range(0, 4));
	endtask

	task automatic test_random_lines(input int target);
		int kind;
		int ax;
		int ay;
		int bx;
		int by;
		int span;
		int len;
		int steps;
		while (items_sent < target) begin
			kind = $urandom_range(0, 4);
			span = 12;
			case (kind)
				0: begin
					ax = $urandom_range(0, 7);
					ay = $urandom_range(0, 7);
					span = 6;
				end
				1: begin
					ax = int'($urandom_range(0, 10)) - 5;
					ay = int'($urandom_range(0, 10)) - 5;
				end
				2: begin
					ax = $urandom_range(630, 649);
					ay = $urandom_range(470, 489);
				end
				3: begin
					ax = $urandom_range(0, 1) ? 639 : 0;
					ay = $urandom_range(0, 1) ? 479 : 0;
				end
				default: begin
					ax = $urandom_range(0, 639);
					ay = $urandom_range(0, 479);
					span = 20;
				end
			endcase
			bx = ax + int'($urandom_range(0, 2 * span)) - span;
			by = ay + int'($urandom_range(0, 2 * span)) - span;
			len = line_pixels(ax, ay, bx, by);
			case ($urandom_range(0, 9))
				0: steps = $urandom_range(0, len - 1);
				1: steps = len + $urandom_range(1, 2);
				default: steps = len;
			endcase
			run_line(ax, ay, bx, by, color_t'($urandom), steps);
		end
	endtask

	initial begin
		foreach (shadow_fb[i])
			shadow_fb[i] = '0;
		walk_active    = 1'b0;
		mismatch_count = 0;
		items_sent     = 0;
		pop_run        = 0;
		arst_n     <= 1'b0;
		push       <= 1'b0;
		mode       <= MODE_STEP;
		start_x    <= '0;
		start_y    <= '0;
		end_x      <= '0;
		end_y      <= '0;
		line_red   <= '0;
		line_green <= '0;
		line_blue  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 12);
		test_directed();
		test_long_lines();
		test_full_range_restart(60);
		test_random_lines(1550);
		push <= 1'b0;
		while (pixel_queue.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0 && pixel_queue.size() == 0)
			$display("line_rasterizer_additive_plot verification clean");
		else
			$display("line_rasterizer_additive_plot verification failed");
		$finish;
	end

endmodule

// File: line_rasterizer_additive_plot.f
rtl/lrap_pkg.sv
rtl/lrap_front.sv
rtl/lrap_queue.sv
rtl/lrap_back.sv
rtl/line_rasterizer_additive_plot.sv
verif/line_rasterizer_additive_plot_tb.sv
